@@ hdl/lcg_keyed_word_decryptor_unit_defines.svh @@
// Assertion macros shared by the decryptor checker.
// No dependencies; included by lkwd_checker.sv.
`ifndef LCG_KEYED_WORD_DECRYPTOR_UNIT_DEFINES_SVH
`define LCG_KEYED_WORD_DECRYPTOR_UNIT_DEFINES_SVH

// check that holds outside reset
`define LKWD_ASSERT(label, pr) \
  label: assert property (@(posedge clk) disable iff (rst) pr) \
    else $error("lkwd assertion failed");

// check that also covers the reset cycles
`define LKWD_ASSERT_RST(label, pr) \
  label: assert property (@(posedge clk) pr) \
    else $error("lkwd reset assertion failed");

`endif

@@ hdl/lkwd_pkg.sv @@
// Types and constants for the LCG keyed word decryptor.
// No dependencies; used by every module of the block.
`default_nettype none
package lkwd_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] OFFSET_BIAS  = 32'h0753_4682;
  localparam logic [WORD_W-1:0] KEY_BIAS     = 32'h0378_6425;
  localparam logic [WORD_W-1:0] LCG_MUL      = 32'h41C6_4E6D;
  localparam logic [WORD_W-1:0] LCG_ADD      = 32'h0000_9B06;
  localparam logic [WORD_W-1:0] HEADER_BYTES = 32'd16;

  localparam int unsigned INDEX_W = 30;
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SIZE   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_SEED   = 2'd2
  } reg_idx_t;

  // one queued item: an optional word result, then an optional zero terminator
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              word_valid;
    logic              word_last;
    logic              term;
  } entry_t;

endpackage
`default_nettype wire

@@ hdl/lkwd_front.sv @@
// Front end: config registers, stream key state and per-item classification.
// Depends on lkwd_pkg.
`default_nettype none
module lkwd_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [lkwd_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [lkwd_pkg::WORD_W-1:0]    wr_data,
  input  wire logic                           accept,
  input  wire logic [lkwd_pkg::WORD_W-1:0]    data_word,
  input  wire logic                           is_last,
  output logic                                enq,
  output lkwd_pkg::entry_t                    entry
);

  logic [lkwd_pkg::WORD_W-1:0]  size_field;
  logic [lkwd_pkg::WORD_W-1:0]  offset_field;
  logic [lkwd_pkg::WORD_W-1:0]  seed_word;
  logic [lkwd_pkg::WORD_W-1:0]  running_key;
  logic [lkwd_pkg::INDEX_W-1:0] word_index;
  logic                         first_pending;

  logic [lkwd_pkg::WORD_W-1:0] key_off;
  logic [lkwd_pkg::WORD_W-1:0] key_pos;
  logic [lkwd_pkg::WORD_W-1:0] cur_key;
  logic [lkwd_pkg::WORD_W-1:0] step_key;
  logic [lkwd_pkg::WORD_W-1:0] value;
  logic                        bypass;
  logic                        at_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_field   <= '0;
      offset_field <= '0;
      seed_word    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        lkwd_pkg::REG_SIZE:   size_field   <= wr_data;
        lkwd_pkg::REG_OFFSET: offset_field <= wr_data;
        lkwd_pkg::REG_SEED:   seed_word    <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    key_off  = offset_field - lkwd_pkg::OFFSET_BIAS;
    bypass   = (key_off == '0);
    key_pos  = key_off - lkwd_pkg::HEADER_BYTES;
    cur_key  = first_pending ? (seed_word + key_off + lkwd_pkg::KEY_BIAS) : running_key;
    step_key = cur_key * lkwd_pkg::LCG_MUL + lkwd_pkg::LCG_ADD;
    at_key   = (key_pos[1:0] == 2'b00) && (key_pos[lkwd_pkg::WORD_W-1:2] == word_index);
    value    = at_key ? data_word : (data_word - size_field - cur_key);

    if (bypass) begin
      entry.word       = data_word;
      entry.word_valid = 1'b1;
      entry.word_last  = is_last;
      entry.term       = 1'b0;
    end else begin
      entry.word       = value;
      entry.word_valid = !first_pending;
      entry.word_last  = 1'b0;
      entry.term       = is_last;
    end
    enq = accept && (entry.word_valid || entry.term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_key   <= '0;
      word_index    <= '0;
      first_pending <= 1'b1;
    end else if (accept && !bypass) begin
      if (is_last) begin
        running_key   <= '0;
        word_index    <= '0;
        first_pending <= 1'b1;
      end else begin
        running_key   <= step_key;
        word_index    <= word_index + 1'b1;
        first_pending <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/lkwd_queue.sv @@
// Short item queue between the front end and the result stage.
// Depends on lkwd_pkg.
`default_nettype none
module lkwd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              enq,
  input  wire lkwd_pkg::entry_t  enq_entry,
  input  wire logic              deq,
  output logic                   full,
  output logic                   q_valid,
  output lkwd_pkg::entry_t       head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lkwd_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= enq_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/lkwd_back.sv @@
// Result stage: expands queued items into one or two results, output register.
// Depends on lkwd_pkg.
`default_nettype none
module lkwd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire lkwd_pkg::entry_t            head,
  input  wire logic                        pop,
  output logic                             deq,
  output logic                             empty,
  output logic [lkwd_pkg::WORD_W-1:0]      out_word,
  output logic                             out_last
);

  logic out_valid;
  logic phase;      // word part of the head item already sent
  logic load;
  logic send_word;

  assign empty     = !out_valid;
  assign load      = q_valid && (!out_valid || pop);
  assign send_word = head.word_valid && !phase;
  assign deq       = load && (!send_word || !head.term);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= send_word && head.term;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_word) begin
        out_word <= head.word;
        out_last <= head.word_last;
      end else begin
        out_word <= '0;
        out_last <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/lcg_keyed_word_decryptor_unit.sv @@
// LCG keyed word decryptor, top level.
// Depends on lkwd_pkg, lkwd_front, lkwd_queue, lkwd_back.
//
// Usage:
//   Input queue port: present data_word/is_last with push; the item is taken
//   at a clock edge with push high and full low. Result queue port: while
//   empty is low, out_word/out_last hold the oldest result; pop takes it.
//   Config: wr_en/wr_index/wr_data write size_field (0), offset_field (1),
//   seed_word (2); other indexes are ignored. Write only while
//   the block holds no pending items.
//   Each item gives zero, one or two results. The front end computes the
//   key step and decrypted word in the cycle of acceptance; the first result
//   of an item reaches the result ports through the queue and the output register.
//   Throughput: one item per cycle while full is low; an item that also closes
//   a keyed stream needs two pops, the result register being the limit.
//   The queue holds QUEUE_DEPTH items; when the receiver stalls it fills and
//   full rises, holding off the sender without losing anything.
//   Reset (rst, synchronous) clears the registers, the stream state and the
//   queue; empty is high and full low after it.
`default_nettype none
module lcg_keyed_word_decryptor_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [lkwd_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [lkwd_pkg::WORD_W-1:0]    wr_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [lkwd_pkg::WORD_W-1:0]    data_word,
  input  wire logic                           is_last,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [lkwd_pkg::WORD_W-1:0]         out_word,
  output logic                                out_last
);

  logic             accept;
  logic             enq;
  logic             deq;
  logic             q_valid;
  lkwd_pkg::entry_t entry;
  lkwd_pkg::entry_t head;

  assign accept = push && !full;

  lkwd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .accept    (accept),
    .data_word (data_word),
    .is_last   (is_last),
    .enq       (enq),
    .entry     (entry)
  );

  lkwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq       (enq),
    .enq_entry (entry),
    .deq       (deq),
    .full      (full),
    .q_valid   (q_valid),
    .head      (head)
  );

  lkwd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .deq      (deq),
    .empty    (empty),
    .out_word (out_word),
    .out_last (out_last)
  );

endmodule
`default_nettype wire

@@ hdl/lkwd_checker.sv @@
// Port-level checks for the decryptor, bound to the top level.
// Depends on lkwd_pkg and lcg_keyed_word_decryptor_unit_defines.svh.
`default_nettype none
`include "lcg_keyed_word_decryptor_unit_defines.svh"
module lkwd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        push,
  input wire logic                        full,
  input wire logic                        is_last,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [lkwd_pkg::WORD_W-1:0] out_word,
  input wire logic                        out_last
);

  `LKWD_ASSERT_RST(a_reset_clears, rst |=> (empty && !full))
  `LKWD_ASSERT(a_full_has_result, full |-> !empty)
  `LKWD_ASSERT(a_last_gives_result, (push && !full && is_last) |=> ##1 !empty)
  `LKWD_ASSERT(a_stall_holds, (!empty && !pop) |=> (!empty && $stable(out_word) && $stable(out_last)))

endmodule

bind lcg_keyed_word_decryptor_unit lkwd_checker u_lkwd_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .is_last  (is_last),
  .empty    (empty),
  .pop      (pop),
  .out_word (out_word),
  .out_last (out_last)
);
`default_nettype wire
